### hw/rtl/irfn_pkg.sv
package irfn_pkg;

    // Default sizes of the frame store
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    // Fixed field widths
    localparam int PIX_W     = 16;
    localparam int MODE_W    = 3;
    localparam int DIM_CFG_W = 11;
    localparam int TONE_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [MODE_W-1:0]    MODE_RST     = 3'd0;
    localparam logic [DIM_CFG_W-1:0] WIDTH_RST    = 11'd1024;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RST   = 11'd1024;
    localparam logic [TONE_W-1:0]    MAX_TONE_RST = 16'd255;

    // Transform modes; codes above MODE_NEGATIVE pass pixels through
    localparam logic [MODE_W-1:0] MODE_ROT_CW    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_CCW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIRROR_V  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIRROR_H  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEGATIVE  = 3'd4;

    // Request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_MAX_TONE
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_end;
        logic             frame_end;
        logic             status;
    } result_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic err;
        logic mul;
        logic rd;
        logic out;
    } cmd_t;

    typedef struct packed {
        logic frame_ready;
    } status_t;

endpackage

### hw/rtl/irfn_ram.sv
module irfn_ram
    import irfn_pkg::*;
#(
    parameter int WIDTH = PIXEL_BITS_DEF,
    parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/irfn_ctrl.sv
module irfn_ctrl
    import irfn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    req_type,
    input  status_t stat,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (stat.frame_ready)
                    begin
                        cmd.fetch  = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.err = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### hw/rtl/irfn_dp.sv
module irfn_dp
    import irfn_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  cmd_t                 cmd,
    output status_t              stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output result_t              result
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_W   = (W_W > H_W) ? W_W : H_W;
    localparam int CW      = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    localparam int TOT_W   = ADDR_W + 1;
    localparam int PROD_W  = ADDR_W + DIM_W + 1;
    localparam bit IS_POW2 = (DEPTH == (1 << ADDR_W));

    // Configuration registers
    logic [MODE_W-1:0]    mode_reg;
    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    logic [TONE_W-1:0]    max_tone_reg;

    // Frame state
    logic [ADDR_W-1:0]    load_index_reg;
    logic [DIM_W-1:0]     out_row_reg;
    logic [DIM_W-1:0]     out_col_reg;
    logic                 frame_ready_reg;

    // Fetch pipeline payload
    logic [ADDR_W-1:0]    row_sel_reg;
    logic [ADDR_W-1:0]    col_sel_reg;
    logic                 re_reg;
    logic                 fe_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 done_reg;
    result_t              result_reg;

    logic [CW-1:0]        width_ext;
    logic [CW-1:0]        height_ext;
    logic [DIM_W-1:0]     w_dim;
    logic [DIM_W-1:0]     h_dim;
    logic [TOT_W-1:0]     total;
    logic [TOT_W-1:0]     load_next;
    logic                 load_done;
    logic                 rot;
    logic [DIM_W-1:0]     row_len;
    logic [DIM_W-1:0]     n_rows;
    logic [DIM_W:0]       col_inc;
    logic [DIM_W:0]       row_inc;
    logic                 re;
    logic                 fe;
    logic [ADDR_W-1:0]    ar;
    logic [ADDR_W-1:0]    ac;
    logic [ADDR_W-1:0]    h_m1;
    logic [ADDR_W-1:0]    w_m1;
    logic [ADDR_W-1:0]    row_sel;
    logic [ADDR_W-1:0]    col_sel;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 ram_we;
    logic [PIXEL_BITS-1:0] rdata;
    logic [TONE_W-1:0]    rd_ext;
    logic [TONE_W-1:0]    tone_diff;
    logic [TONE_W-1:0]    pix_val;

    // Dimensions saturate to 1..MAX
    assign width_ext  = CW'(width_reg);
    assign height_ext = CW'(height_reg);
    assign w_dim = (width_reg == '0) ? DIM_W'(1) :
                   (width_ext > CW'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_ext);
    assign h_dim = (height_reg == '0) ? DIM_W'(1) :
                   (height_ext > CW'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(height_ext);

    assign total     = TOT_W'(w_dim) * TOT_W'(h_dim);
    assign load_next = TOT_W'(load_index_reg) + TOT_W'(1);
    assign load_done = (load_next >= total);

    assign rot     = (mode_reg == MODE_ROT_CW) || (mode_reg == MODE_ROT_CCW);
    assign row_len = rot ? h_dim : w_dim;
    assign n_rows  = rot ? w_dim : h_dim;
    assign col_inc = {1'b0, out_col_reg} + (DIM_W + 1)'(1);
    assign row_inc = {1'b0, out_row_reg} + (DIM_W + 1)'(1);
    assign re      = (col_inc >= {1'b0, row_len});
    assign fe      = re && (row_inc >= {1'b0, n_rows});

    // Source coordinates, kept modulo the store size
    assign ar   = ADDR_W'(out_row_reg);
    assign ac   = ADDR_W'(out_col_reg);
    assign h_m1 = ADDR_W'(h_dim) - ADDR_W'(1);
    assign w_m1 = ADDR_W'(w_dim) - ADDR_W'(1);

    always_comb
    begin
        unique case (mode_reg)
            MODE_ROT_CW:
            begin
                row_sel = h_m1 - ac;
                col_sel = ar;
            end
            MODE_ROT_CCW:
            begin
                row_sel = ac;
                col_sel = w_m1 - ar;
            end
            MODE_MIRROR_V:
            begin
                row_sel = h_m1 - ar;
                col_sel = ac;
            end
            MODE_MIRROR_H:
            begin
                row_sel = ar;
                col_sel = w_m1 - ac;
            end
            default:
            begin
                row_sel = ar;
                col_sel = ac;
            end
        endcase
    end

    always_comb
    begin
        if (IS_POW2)
        begin
            rd_addr = prod_reg[ADDR_W-1:0];
        end
        else if (prod_reg >= PROD_W'(DEPTH))
        begin
            rd_addr = ADDR_W'(prod_reg - PROD_W'(DEPTH));
        end
        else
        begin
            rd_addr = ADDR_W'(prod_reg);
        end
    end

    assign ram_we = cmd.load && !frame_ready_reg;

    irfn_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_index_reg),
        .wdata (req.pixel[PIXEL_BITS-1:0]),
        .re    (cmd.rd),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Negative saturates at zero
    assign rd_ext    = TONE_W'(rdata);
    assign tone_diff = max_tone_reg - rd_ext;

    always_comb
    begin
        if (mode_reg == MODE_NEGATIVE)
        begin
            pix_val = (rd_ext > max_tone_reg) ? '0 : tone_diff;
        end
        else
        begin
            pix_val = rd_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RST;
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            max_tone_reg <= MAX_TONE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                CFG_WIDTH:    width_reg    <= cfg_data[DIM_CFG_W-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[DIM_CFG_W-1:0];
                CFG_MAX_TONE: max_tone_reg <= cfg_data[TONE_W-1:0];
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg  <= '0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            frame_ready_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            if (load_done)
            begin
                load_index_reg  <= '0;
                frame_ready_reg <= 1'b1;
                out_row_reg     <= '0;
                out_col_reg     <= '0;
            end
            else
            begin
                load_index_reg <= load_next[ADDR_W-1:0];
            end
        end
        else if (cmd.fetch)
        begin
            if (fe)
            begin
                frame_ready_reg <= 1'b0;
                out_row_reg     <= '0;
                out_col_reg     <= '0;
                load_index_reg  <= '0;
            end
            else if (re)
            begin
                out_col_reg <= '0;
                out_row_reg <= row_inc[DIM_W-1:0];
            end
            else
            begin
                out_col_reg <= col_inc[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            row_sel_reg <= row_sel;
            col_sel_reg <= col_sel;
            re_reg      <= re;
            fe_reg      <= fe;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(row_sel_reg) * PROD_W'(w_dim) + PROD_W'(col_sel_reg);
        end
        if (cmd.err)
        begin
            result_reg.pixel_out <= '0;
            result_reg.row_end   <= 1'b0;
            result_reg.frame_end <= 1'b0;
            result_reg.status    <= 1'b1;
        end
        else if (cmd.out)
        begin
            result_reg.pixel_out <= PIX_W'(pix_val[PIXEL_BITS-1:0]);
            result_reg.row_end   <= re_reg;
            result_reg.frame_end <= fe_reg;
            result_reg.status    <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.err || cmd.out;
        end
    end

    assign stat.frame_ready = frame_ready_reg;
    assign done             = done_reg;
    assign result           = result_reg;

endmodule

### hw/rtl/image_rotate_flip_negate.sv
// Channel   Ports                          Transfer
// -------   -----------------------------  ---------------------------------
// request   start, busy, req               start high while busy low
// result    done, result                   done high, one cycle, no backpressure
// config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// A load never raises busy; unless a frame is ready, its pixel is written to the
// frame store at the transfer edge. A fetch on a ready frame holds busy through
// the address multiply, store read and transform states of the controller's fetch
// sequence, and done rises as busy falls; no new request is taken until then.
// A fetch without a ready frame answers with status 1 in the next cycle.
// Reset clears control, configuration registers and counters; the frame store is not cleared.
module image_rotate_flip_negate
    import irfn_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t stat;

    irfn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    irfn_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule

### tb/irfn_transform_check.sv
module irfn_transform_check
    import irfn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  req_t                 req,
    input  logic                 done,
    input  result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int unsigned          fails = 0,
    output int unsigned          outstanding = 0,
    output int unsigned          frame_pixels = 1
);

    localparam int unsigned STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam logic [PIX_W-1:0] PIX_MASK = {PIX_W{1'b1}} >> (PIX_W - PIXEL_BITS_DEF);

    // shadow of the block's registers and frame state
    logic [MODE_W-1:0]    mode_q   = MODE_RST;
    logic [DIM_CFG_W-1:0] width_q  = WIDTH_RST;
    logic [DIM_CFG_W-1:0] height_q = HEIGHT_RST;
    logic [TONE_W-1:0]    tone_q   = MAX_TONE_RST;

    logic [PIX_W-1:0] frame_mem [int unsigned];
    int unsigned      load_ptr = 0;
    int unsigned      row_ptr = 0;
    int unsigned      col_ptr = 0;
    bit               ready = 1'b0;

    result_t pixels_due [$];
    result_t oldest;

    function automatic int unsigned fit_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [PIX_W-1:0] mem_read(int unsigned r, int unsigned c,
                                                  int unsigned w);
        longint unsigned a;
        int unsigned     key;
        a = 64'(r) * 64'(w) + 64'(c);
        key = 32'(a % STORE_DEPTH);
        return frame_mem.exists(key) ? frame_mem[key] : '0;
    endfunction

    // Apply one accepted request; fetches queue the pixel the block must return.
    function void transform_step(req_t item);
        int unsigned      w;
        int unsigned      h;
        int unsigned      total;
        int unsigned      row_len;
        int unsigned      n_rows;
        int unsigned      r;
        int unsigned      c;
        bit               rot;
        bit               re;
        bit               fe;
        logic [PIX_W-1:0] v;
        result_t          predicted;
        w = fit_dim(width_q, MAX_WIDTH_DEF);
        h = fit_dim(height_q, MAX_HEIGHT_DEF);
        total = w * h;
        rot = (mode_q == MODE_ROT_CW) || (mode_q == MODE_ROT_CCW);
        row_len = rot ? h : w;
        n_rows = rot ? w : h;
        predicted = '0;

        if (item.req_type == REQ_LOAD) begin
            if (!ready) begin
                frame_mem[load_ptr % STORE_DEPTH] = item.pixel & PIX_MASK;
                load_ptr++;
                if (load_ptr >= total) begin
                    load_ptr = 0;
                    ready = 1'b1;
                    row_ptr = 0;
                    col_ptr = 0;
                end
            end
            return;
        end

        if (!ready) begin
            predicted.status = 1'b1;
            pixels_due.push_back(predicted);
            return;
        end

        r = row_ptr;
        c = col_ptr;
        case (mode_q)
            MODE_ROT_CW:   v = mem_read(h - 1 - c, r, w);
            MODE_ROT_CCW:  v = mem_read(c, w - 1 - r, w);
            MODE_MIRROR_V: v = mem_read(h - 1 - r, c, w);
            MODE_MIRROR_H: v = mem_read(r, w - 1 - c, w);
            MODE_NEGATIVE: begin
                v = mem_read(r, c, w);
                v = (v > tone_q) ? '0 : tone_q - v;
            end
            default:       v = mem_read(r, c, w);
        endcase

        re = (col_ptr + 1 >= row_len);
        fe = re && (row_ptr + 1 >= n_rows);
        if (fe) begin
            ready = 1'b0;
            row_ptr = 0;
            col_ptr = 0;
            load_ptr = 0;
        end else if (re) begin
            col_ptr = 0;
            row_ptr++;
        end else begin
            col_ptr++;
        end

        predicted.pixel_out = v & PIX_MASK;
        predicted.row_end = re;
        predicted.frame_end = fe;
        pixels_due.push_back(predicted);
    endfunction

    function void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_q = MODE_RST;
            width_q = WIDTH_RST;
            height_q = HEIGHT_RST;
            tone_q = MAX_TONE_RST;
            frame_mem.delete();
            load_ptr = 0;
            row_ptr = 0;
            col_ptr = 0;
            ready = 1'b0;
            pixels_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE:     mode_q = cfg_data[MODE_W-1:0];
                    CFG_WIDTH:    width_q = cfg_data[DIM_CFG_W-1:0];
                    CFG_HEIGHT:   height_q = cfg_data[DIM_CFG_W-1:0];
                    CFG_MAX_TONE: tone_q = cfg_data[TONE_W-1:0];
                    default: ;
                endcase
            end
            // results belong to older requests, so compare before queueing a new one
            if (done) begin
                if (pixels_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none actual %h", $time, result);
                end else begin
                    oldest = pixels_due.pop_front();
                    check_field("pixel_out", oldest.pixel_out, result.pixel_out);
                    check_field("row_end", oldest.row_end, result.row_end);
                    check_field("frame_end", oldest.frame_end, result.frame_end);
                    check_field("status", oldest.status, result.status);
                end
            end
            if (start && !busy)
                transform_step(req);
        end
        outstanding = pixels_due.size();
        frame_pixels = fit_dim(width_q, MAX_WIDTH_DEF) * fit_dim(height_q, MAX_HEIGHT_DEF);
    end

endmodule

### tb/tb_image_rotate_flip_negate.sv
module tb_image_rotate_flip_negate;
    import irfn_pkg::*;

    typedef enum int {
        PLAIN,
        RESIZE_MID_LOAD,
        REMODE_MID_FETCH,
        RETONE_MID_FETCH
    } upset_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    req_t                 req = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int unsigned fails;
    int unsigned outstanding;
    int unsigned frame_pixels;

    bit               idling = 1'b0;
    int unsigned      sent = 0;
    logic [TONE_W-1:0] tone_w = MAX_TONE_RST;

    always #2 clk = ~clk;

    image_rotate_flip_negate uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    irfn_transform_check transform_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .done         (done),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .outstanding  (outstanding),
        .frame_pixels (frame_pixels)
    );

    // One request transfer, with an occasional idle burst in front of it.
    task automatic issue(logic kind, logic [PIX_W-1:0] pix);
        int unsigned n;
        if (idling && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 18);
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req <= '{req_type: kind, pixel: pix};
        do @(posedge clk); while (busy);
    endtask

    // Drain all results and give trailing loads time before touching registers.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return tone_w;
            3: return tone_w + 1'b1;
            4: return tone_w - 1'b1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return DIM_CFG_W'(1);
            2, 3: return DIM_CFG_W'($urandom_range(9, 24));
            default: return DIM_CFG_W'($urandom_range(2, 8));
        endcase
    endfunction

    // Loads with a few stray fetches mixed in; those answer with status 1.
    task automatic load_pixels(int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 29) == 0) begin
                issue(REQ_FETCH, PIX_W'($urandom));
                sent++;
            end
            issue(REQ_LOAD, pick_pixel());
            sent++;
        end
    endtask

    // Fetches with stray loads mixed in; the frame is ready so those are dropped.
    task automatic fetch_pixels(int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0)
                issue(REQ_LOAD, PIX_W'($urandom));
            issue(REQ_FETCH, PIX_W'($urandom));
            sent++;
        end
    endtask

    task automatic play_frame(logic [MODE_W-1:0] m, logic [DIM_CFG_W-1:0] wd,
                              logic [DIM_CFG_W-1:0] ht, logic [TONE_W-1:0] tone,
                              upset_t how);
        logic [15:0]          junk;
        logic [DIM_CFG_W-1:0] nd;
        int unsigned          total;
        int unsigned          part;
        junk = 16'($urandom);
        write_reg(CFG_MODE, {junk[15:MODE_W], m});
        write_reg(CFG_WIDTH, {junk[15:DIM_CFG_W], wd});
        write_reg(CFG_HEIGHT, {junk[4:0], ht});
        write_reg(CFG_MAX_TONE, tone);
        tone_w = tone;
        total = frame_pixels;

        if (how == RESIZE_MID_LOAD && total > 1) begin
            // new size takes effect at once; load ends when the new count is reached
            part = $urandom_range(1, total - 1);
            load_pixels(part);
            nd = pick_dim();
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_WIDTH, nd);
            else
                write_reg(CFG_HEIGHT, nd);
            total = frame_pixels;
            load_pixels((part >= total) ? 1 : total - part);
        end else begin
            load_pixels(total);
        end

        if ((how == REMODE_MID_FETCH || how == RETONE_MID_FETCH) && total > 1) begin
            part = $urandom_range(1, total - 1);
            fetch_pixels(part);
            // mode swaps only on square frames so the walk stays inside the image
            if (how == REMODE_MID_FETCH)
                write_reg(CFG_MODE, CFG_W'($urandom_range(0, {MODE_W{1'b1}})));
            tone_w = TONE_W'($urandom);
            write_reg(CFG_MAX_TONE, tone_w);
            fetch_pixels(total - part);
        end else begin
            fetch_pixels(total);
        end
    endtask

    task automatic run_frame();
        upset_t               how;
        logic [MODE_W-1:0]    m;
        logic [DIM_CFG_W-1:0] wd;
        logic [DIM_CFG_W-1:0] ht;
        logic [TONE_W-1:0]    tone;
        case ($urandom_range(0, 9))
            0: how = RESIZE_MID_LOAD;
            1: how = REMODE_MID_FETCH;
            2: how = RETONE_MID_FETCH;
            default: how = PLAIN;
        endcase
        if ($urandom_range(0, 7) == 0)
            m = MODE_W'($urandom_range(MODE_NEGATIVE + 1, {MODE_W{1'b1}}));
        else
            m = MODE_W'($urandom_range(MODE_ROT_CW, MODE_NEGATIVE));
        wd = pick_dim();
        ht = (how == REMODE_MID_FETCH || $urandom_range(0, 5) == 0) ? wd : pick_dim();
        case ($urandom_range(0, 3))
            0: tone = TONE_W'(1);
            1: tone = '1;
            2: tone = TONE_W'($urandom);
            default: tone = MAX_TONE_RST;
        endcase
        play_frame(m, wd, ht, tone, how);
    endtask

    initial begin
        int unsigned tail_mark;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // no frame loaded yet
        issue(REQ_FETCH, '1);

        // 2x3 clockwise rotation with extreme pixels, then a load on a ready frame
        write_reg(CFG_WIDTH, CFG_W'(2));
        write_reg(CFG_HEIGHT, CFG_W'(3));
        issue(REQ_LOAD, 16'h0000);
        issue(REQ_LOAD, 16'hFFFF);
        issue(REQ_LOAD, 16'h0001);
        issue(REQ_LOAD, 16'h8000);
        issue(REQ_LOAD, 16'h7FFF);
        issue(REQ_LOAD, 16'h5A5A);
        issue(REQ_LOAD, 16'h1234);
        repeat (6) issue(REQ_FETCH, 16'h0000);

        // negative with a tone of one, height zero clamps to one row
        write_reg(CFG_MODE, CFG_W'(MODE_NEGATIVE));
        write_reg(CFG_MAX_TONE, CFG_W'(1));
        write_reg(CFG_HEIGHT, '0);
        issue(REQ_LOAD, 16'h0000);
        issue(REQ_LOAD, 16'hFFFF);
        repeat (2) issue(REQ_FETCH, 16'hFFFF);

        // pass-through mode code, width zero clamps to one pixel
        write_reg(CFG_MODE, CFG_W'({MODE_W{1'b1}}));
        write_reg(CFG_WIDTH, '0);
        issue(REQ_LOAD, 16'hAAAA);
        issue(REQ_FETCH, 16'h5555);

        while (sent < 950) begin
            idling = ($urandom_range(0, 3) != 0);
            run_frame();
        end

        // widest and tallest sizes, written beyond the store limits; a shrink
        // mid-load ends each frame after a few pixels
        idling = 1'b1;
        write_reg(CFG_MODE, CFG_W'(MODE_MIRROR_H));
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, '0);
        load_pixels(5);
        write_reg(CFG_WIDTH, CFG_W'(6));
        load_pixels(1);
        fetch_pixels(6);

        write_reg(CFG_MODE, CFG_W'(MODE_ROT_CCW));
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, '1);
        load_pixels(5);
        write_reg(CFG_HEIGHT, CFG_W'(6));
        load_pixels(1);
        fetch_pixels(6);

        idling = 1'b0;
        tail_mark = sent;
        while (sent < tail_mark + 50)
            run_frame();

        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/irfn_pkg.sv
hw/rtl/irfn_ram.sv
hw/rtl/irfn_ctrl.sv
hw/rtl/irfn_dp.sv
hw/rtl/image_rotate_flip_negate.sv
tb/irfn_transform_check.sv
tb/tb_image_rotate_flip_negate.sv
